// ===== rtl/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: result status codes, register
// indexes and the structs passed between the decoder modules.
// No dependencies.
package utf8d_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_CONT = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_END_ERR  = 3'd4;
  localparam logic [2:0] ST_TOO_WIDE = 3'd5;
  localparam logic [2:0] ST_NUL      = 3'd6;

  // Configuration register indexes
  localparam logic CFG_WIDE_CHARS_32 = 1'b0;
  localparam logic CFG_REJECT_NUL    = 1'b1;

  localparam int unsigned CP_W = 31;

  // Configuration register contents
  typedef struct packed {
    logic wide_chars_32;
    logic reject_nul;
  } utf8d_cfg_t;

  // Registered input word
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } utf8d_word_t;

  // One decoded result, valid when the word produces a result
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic [2:0]      seq_length;
    logic [2:0]      status;
    logic            end_of_string;
  } utf8d_result_t;

endpackage

// ===== rtl/utf8d_in_stage.sv =====
// Input register of the UTF-8 stream decoder: captures one word per accept
// and holds it until the decode step consumes it.
// Depends on utf8d_pkg.
module utf8d_in_stage
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        consume,
  output utf8d_word_t word
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // Refill on accept, drop once consumed, otherwise hold
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign word.valid     = valid_r;
  assign word.data_byte = byte_r;
  assign word.last_byte = last_r;

endmodule

// ===== rtl/utf8d_decode.sv =====
// Decode step of the UTF-8 stream decoder: sequence state registers and the
// combinational logic that turns one word into zero or one result.
// Depends on utf8d_pkg.
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  utf8d_word_t   word,
  input  logic          step,
  input  utf8d_cfg_t    cfg,
  output utf8d_result_t result
);

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [2:0]      pending_r, pending_nxt;
  logic [2:0]      size_r, size_nxt;
  logic            poisoned_r, poisoned_nxt;

  logic [7:0]      b;
  logic            last;
  logic [2:0]      lead_size;
  logic [CP_W-1:0] lead_bits;
  logic [CP_W-1:0] cand_val;
  logic [2:0]      cand_size;
  logic            err;
  logic [2:0]      err_code;
  logic            done;

  assign b    = word.data_byte;
  assign last = word.last_byte;

  // Classify the lead byte; size zero marks a bad lead
  always_comb begin
    lead_size = 3'd0;
    lead_bits = '0;
    casez (b)
      8'b0???_????: begin
        lead_size = 3'd1;
        lead_bits = {{(CP_W-7){1'b0}}, b[6:0]};
      end
      8'b110?_????: begin
        lead_size = 3'd2;
        lead_bits = {{(CP_W-5){1'b0}}, b[4:0]};
      end
      8'b1110_????: begin
        lead_size = 3'd3;
        lead_bits = {{(CP_W-4){1'b0}}, b[3:0]};
      end
      8'b1111_0???: begin
        lead_size = 3'd4;
        lead_bits = {{(CP_W-3){1'b0}}, b[2:0]};
      end
      8'b1111_10??: begin
        lead_size = 3'd5;
        lead_bits = {{(CP_W-2){1'b0}}, b[1:0]};
      end
      8'b1111_110?: begin
        lead_size = 3'd6;
        lead_bits = {{(CP_W-1){1'b0}}, b[0]};
      end
      default: begin
        lead_size = 3'd0;
        lead_bits = '0;
      end
    endcase
  end

  // Next state and result for the word in the input register
  always_comb begin
    partial_nxt  = partial_r;
    pending_nxt  = pending_r;
    size_nxt     = size_r;
    poisoned_nxt = poisoned_r;
    cand_val     = partial_r;
    cand_size    = size_r;
    err          = 1'b0;
    err_code     = ST_OK;
    done         = 1'b0;

    result.valid         = 1'b0;
    result.code_point    = '0;
    result.seq_length    = 3'd0;
    result.status        = ST_OK;
    result.end_of_string = last;

    if (poisoned_r) begin
      // Drop words until the end of the string
      if (last) begin
        result.valid  = 1'b1;
        result.status = ST_END_ERR;
        partial_nxt   = '0;
        pending_nxt   = 3'd0;
        size_nxt      = 3'd0;
        poisoned_nxt  = 1'b0;
      end
    end else begin
      if (pending_r == 3'd0) begin
        // Open a sequence
        if (lead_size == 3'd0) begin
          err      = 1'b1;
          err_code = ST_BAD_LEAD;
        end else begin
          cand_val    = lead_bits;
          cand_size   = lead_size;
          partial_nxt = lead_bits;
          size_nxt    = lead_size;
          pending_nxt = lead_size - 3'd1;
          if (lead_size == 3'd1) begin
            done = 1'b1;
          end else if (last) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
          end
        end
      end else begin
        // Continuation byte
        if (last && pending_r > 3'd1) begin
          err      = 1'b1;
          err_code = ST_TRUNC;
        end else if (b[7:6] != 2'b10) begin
          err      = 1'b1;
          err_code = ST_BAD_CONT;
        end else begin
          cand_val    = {partial_r[CP_W-7:0], b[5:0]};
          partial_nxt = cand_val;
          pending_nxt = pending_r - 3'd1;
          done        = (pending_r == 3'd1);
        end
      end

      // Completion checks on a finished sequence
      if (done) begin
        if (!cfg.wide_chars_32 && cand_size > 3'd3) begin
          err      = 1'b1;
          err_code = ST_TOO_WIDE;
        end else if (cfg.reject_nul && cand_val == '0) begin
          err      = 1'b1;
          err_code = ST_NUL;
        end else begin
          result.valid      = 1'b1;
          result.code_point = cand_val;
          result.seq_length = cand_size;
          partial_nxt       = '0;
          pending_nxt       = 3'd0;
          size_nxt          = 3'd0;
          poisoned_nxt      = 1'b0;
        end
      end

      // Error result: poison the rest of the string unless it ends here
      if (err) begin
        result.valid  = 1'b1;
        result.status = err_code;
        partial_nxt   = '0;
        pending_nxt   = 3'd0;
        size_nxt      = 3'd0;
        poisoned_nxt  = !last;
      end
    end

    // A word that does not step produces nothing
    if (!(step && word.valid)) begin
      result.valid = 1'b0;
    end
  end

  // Advance the sequence state only when the word is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= '0;
      pending_r  <= 3'd0;
      size_r     <= 3'd0;
      poisoned_r <= 1'b0;
    end else if (step && word.valid) begin
      partial_r  <= partial_nxt;
      pending_r  <= pending_nxt;
      size_r     <= size_nxt;
      poisoned_r <= poisoned_nxt;
    end
  end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: configuration registers, input
// register, decode step and result register.
// Depends on utf8d_pkg, utf8d_in_stage and utf8d_decode.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte, in_last_byte | byte in
//  out     | out_valid, out_stall, out_code_point,          | result out
//          | out_seq_length, out_status, out_end_of_string  |
//  cfg     | cfg_we, cfg_index, cfg_wdata                   | write only
//
// One byte per clock while in_stall is low; an accepted byte's result (if any)
// passes through the input register, decode and the result register.
// The decode state updates as each byte moves into the result register.
// in_stall rises only while a held byte cannot move because the result
// register is full and out_stall is high.
// Synchronous active-low reset clears state; configuration resets to wide
// characters (sequences of up to six bytes) with NUL accepted.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic [2:0]      out_seq_length,
  output logic [2:0]      out_status,
  output logic            out_end_of_string,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic            cfg_wdata
);

  utf8d_cfg_t    cfg_r;
  utf8d_word_t   word;
  utf8d_result_t result;
  logic          out_free;
  logic          step;
  logic          out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] cp_r;
  logic [2:0]    len_r;
  logic [2:0]    status_r;
  logic          eos_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_chars_32 <= 1'b1;
      cfg_r.reject_nul    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDE_CHARS_32: cfg_r.wide_chars_32 <= cfg_wdata;
        CFG_REJECT_NUL:    cfg_r.reject_nul    <= cfg_wdata;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // Flow control: the held byte moves when the result register can load
  assign out_free = !out_valid_r || !out_stall;
  assign step     = word.valid && out_free;
  assign in_stall = word.valid && !out_free;

  utf8d_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .consume      (step),
    .word         (word)
  );

  utf8d_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .word   (word),
    .step   (step),
    .cfg    (cfg_r),
    .result (result)
  );

  // Result register: load on step, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_free) begin
      out_valid_nxt = result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && result.valid) begin
      cp_r     <= result.code_point;
      len_r    <= result.seq_length;
      status_r <= result.status;
      eos_r    <= result.end_of_string;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_point    = cp_r;
  assign out_seq_length    = len_r;
  assign out_status        = status_r;
  assign out_end_of_string = eos_r;

`ifndef NO_ASSERTIONS
  // Error results carry no character
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_code_point == '0 && out_seq_length == 3'd0)
    else $error("error result carries a character");

  // Good results carry a sequence length of one to six
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_seq_length != 3'd0 && out_seq_length <= 3'd6)
    else $error("good result with bad sequence length");

  // Input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall && word.valid)
    else $error("input stalled without cause");

  // Closing status only at the end of a string
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_END_ERR |-> out_end_of_string)
    else $error("closing result not at end of string");
`endif

endmodule
